// File: rtl/tabms_pkg.sv
// Shared types and constants for the two-arm bandit mode selector.
package tabms_pkg;

   localparam int QW = 32;
   localparam int RW = 30;
   localparam int FRAC_BITS = 24;
   localparam int DW = 17;
   localparam logic [DW-1:0] DECAY_ONE = 17'd65536;
   localparam logic [15:0] DECAY_STEP = 16'd62259;

   typedef struct packed {
      logic [32:0] x;
      logic [32:0] d;
   } job_type;

endpackage

// File: rtl/tabms_front.sv
// Front end: takes request words and forms log2 argument and divisor.
module tabms_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,
   output logic                   push,
   output tabms_pkg::job_type     push_job,
   input  logic                   q_ready
);

   logic               full_ff, full_in;
   tabms_pkg::job_type job_ff, job_in;

   assign push       = full_ff & q_ready;
   assign push_job   = job_ff;
   assign req_tready = ~full_ff | q_ready;

   always_comb begin
      full_in = full_ff;
      job_in  = job_ff;
      if (push) full_in = 1'b0;
      if (req_tvalid && req_tready) begin
         full_in  = 1'b1;
         job_in.x = {1'b0, req_tdata[31:0]} + 33'd1;
         job_in.d = {1'b0, req_tdata[63:32]} + 33'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      job_ff <= job_in;
   end

endmodule

// File: rtl/tabms_queue.sv
// Two-entry queue between front and back ends.
module tabms_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tabms_pkg::job_type  push_job,
   output logic                q_ready,
   input  logic                pop,
   output logic                q_valid,
   output tabms_pkg::job_type  pop_job
);

   tabms_pkg::job_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign q_ready = cnt_ff != 2'd2;
   assign q_valid = cnt_ff != 2'd0;
   assign pop_job = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_job;
   end

endmodule

// File: rtl/tabms_back.sv
// Back end: iterative log2, divider, value update, scoring and result register.
module tabms_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tabms_pkg::job_type  pop_job,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NORM = 3'd1;
   localparam logic [2:0] S_SQR  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;
   localparam logic [2:0] S_MUL  = 3'd5;
   localparam logic [2:0] S_CMP  = 3'd6;

   logic [2:0]  st_ff, st_in;
   logic [31:0] m_ff, m_in;
   logic [5:0]  e_ff, e_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] d_ff, d_in;
   logic [33:0] rem_ff, rem_in;
   logic [29:0] dvd_ff, dvd_in;
   logic [29:0] quo_ff, quo_in;
   logic [31:0] qn_ff, qn_in;
   logic signed [48:0] prod_ff, prod_in;
   logic [16:0] dnext_ff, dnext_in;

   logic        act_ff, act_in;
   logic signed [31:0] val_ff [2];
   logic signed [31:0] val_in [2];
   logic [29:0] prev_ff [2];
   logic [29:0] prev_in [2];
   logic [16:0] dec_ff, dec_in;

   logic        ov_ff, ov_in;
   logic [63:0] od_ff, od_in;

   logic [63:0] sq;
   logic [33:0] rsh;
   logic signed [35:0] sum;
   logic signed [33:0] qs;
   logic signed [32:0] scur;
   logic        nxt;
   logic [32:0] dmul;

   assign pop        = (st_ff == S_IDLE) & q_valid;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   always_comb begin
      st_in = st_ff; m_in = m_ff; e_in = e_ff; cnt_in = cnt_ff; d_in = d_ff;
      rem_in = rem_ff; dvd_in = dvd_ff; quo_in = quo_ff; qn_in = qn_ff;
      prod_in = prod_ff; dnext_in = dnext_ff; act_in = act_ff;
      val_in = val_ff; prev_in = prev_ff; dec_in = dec_ff;
      ov_in = ov_ff & ~rsp_tready; od_in = od_ff;
      sq   = {32'd0, m_ff} * {32'd0, m_ff};
      rsh  = {rem_ff[32:0], dvd_ff[29]};
      sum  = 36'(signed'(val_ff[act_ff])) * 36'sd3
           + $signed({5'd0, quo_ff, 1'b0}) - $signed({6'd0, prev_ff[act_ff]});
      qs   = sum[35:2];
      scur = prod_ff[48:16];
      nxt  = $signed({val_ff[1][31], val_ff[1]}) > scur;
      if (act_ff) nxt = scur > $signed({val_ff[0][31], val_ff[0]});
      dmul = {16'd0, dec_ff} * {17'd0, tabms_pkg::DECAY_STEP};
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               d_in   = pop_job.d;
               cnt_in = 5'd0;
               if (pop_job.x[32]) begin
                  m_in  = 32'h8000_0000;
                  e_in  = 6'd32;
                  st_in = S_SQR;
               end else begin
                  m_in  = pop_job.x[31:0];
                  e_in  = 6'd31;
                  st_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            if (m_ff[31]) st_in = S_SQR;
            else begin
               m_in = {m_ff[30:0], 1'b0};
               e_in = e_ff - 6'd1;
            end
         end
         S_SQR: begin
            m_in   = sq[63] ? sq[63:32] : sq[62:31];
            dvd_in = {dvd_ff[28:0], sq[63]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(tabms_pkg::FRAC_BITS - 1)) begin
               dvd_in = {e_ff, dvd_ff[22:0], sq[63]};
               rem_in = 34'd0;
               cnt_in = 5'd0;
               st_in  = S_DIV;
            end
         end
         S_DIV: begin
            dvd_in = {dvd_ff[28:0], 1'b0};
            if (rsh >= {1'b0, d_ff}) begin
               rem_in = rsh - {1'b0, d_ff};
               quo_in = {quo_ff[28:0], 1'b1};
            end else begin
               rem_in = rsh;
               quo_in = {quo_ff[28:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd29) st_in = S_UPD;
         end
         S_UPD: begin
            if (qs > 34'sh0_7FFF_FFFF) qn_in = 32'h7FFF_FFFF;
            else if (qs < -34'sh0_8000_0000) qn_in = 32'h8000_0000;
            else qn_in = qs[31:0];
            st_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = 49'(signed'(qn_ff)) * $signed({32'd0, dec_ff});
            dnext_in = dmul[32:16];
            val_in[act_ff]  = qn_ff;
            prev_in[act_ff] = quo_ff;
            st_in = S_CMP;
         end
         S_CMP: begin
            if (!ov_in) begin
               ov_in  = 1'b1;
               od_in  = {qn_ff, quo_ff, nxt != act_ff, nxt};
               dec_in = (nxt != act_ff) ? tabms_pkg::DECAY_ONE : dnext_ff;
               act_in = nxt;
               st_in  = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         act_ff <= 1'b0;
         val_ff <= '{default: '0};
         prev_ff <= '{default: '0};
         dec_ff <= tabms_pkg::DECAY_ONE;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         act_ff <= act_in;
         val_ff <= val_in;
         prev_ff <= prev_in;
         dec_ff <= dec_in;
         ov_ff  <= ov_in;
      end
      m_ff <= m_in; e_ff <= e_in; cnt_ff <= cnt_in; d_ff <= d_in;
      rem_ff <= rem_in; dvd_ff <= dvd_in; quo_ff <= quo_in; qn_ff <= qn_in;
      prod_ff <= prod_in; dnext_ff <= dnext_in; od_ff <= od_in;
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp_tready |=> $stable(od_ff))
      else $error("result changed while stalled");
   a_decay: assert property (@(posedge clock) disable iff (reset)
      dec_ff <= tabms_pkg::DECAY_ONE)
      else $error("decay above one");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> st_ff == S_NORM || st_ff == S_SQR)
      else $error("pop without start");
   a_sw: assert property (@(posedge clock) disable iff (reset)
      ov_in && !ov_ff && od_in[1] |=> dec_ff == tabms_pkg::DECAY_ONE)
      else $error("decay not reset on switch");
`endif

endmodule

// File: rtl/two_arm_bandit_mode_selector_top.sv
// Two-arm bandit mode selector, top level.
// Path from accept to result valid: front register, queue write, normalize,
// 24 log2 squaring steps, 30 divider steps, then the update, multiply and compare states.
// The back end takes one word per pass and pops the next word only when idle;
// a stalled result holds the back end.
// Reset: synchronous; clears values, rewards, active arm and sets decay to 1.0.
module two_arm_bandit_mode_selector_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // phase_conflicts[31:0], phase_decisions[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // next_arm[0], switched[1], phase_reward[31:2],
                                    // updated_value[63:32]
);

   logic push, q_ready, pop, q_valid;
   tabms_pkg::job_type push_job, pop_job;

   tabms_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .push, .push_job, .q_ready
   );

   tabms_queue u_queue (
      .clock, .reset, .push, .push_job, .q_ready, .pop, .q_valid, .pop_job
   );

   tabms_back u_back (
      .clock, .reset, .q_valid, .pop_job, .pop, .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule
